/* sv/keyboard_command_dispatcher_assert.svh */
// Assertion macros for the keyboard command dispatcher.
// Needs clk and rst_n in the scope of use; empty when SYNTHESIS is defined.
`ifndef KEYBOARD_COMMAND_DISPATCHER_ASSERT_SVH
`define KEYBOARD_COMMAND_DISPATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define KCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KCD_ASSERT_NOW(label, ante, cons, msg)
`define KCD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* sv/kcd_pkg.sv */
// Shared types, codes and helpers for the keyboard command dispatcher.
// No dependencies.
package kcd_pkg;

    localparam int KCD_MAX_CMD_BYTES = 64;
    localparam int KCD_LEN_W         = 7;
    localparam int KCD_OWNER_DEPTH   = 128;

    localparam logic [7:0] KCD_SOURCE_RESET = 8'd255;
    localparam logic [7:0] KCD_CH_PERCENT   = 8'd37;
    localparam logic [7:0] KCD_CH_CR        = 8'd13;

    localparam logic [1:0] KCD_KIND_BYTE    = 2'd0;
    localparam logic [1:0] KCD_KIND_CANNOT  = 2'd1;
    localparam logic [1:0] KCD_KIND_INVALID = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT
    } kcd_state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_REG,
        ACT_START,
        ACT_FIRST,
        ACT_APPEND,
        ACT_EMIT,
        ACT_ERR_INV,
        ACT_ERR_CANNOT
    } kcd_act_t;

    // '0'-'9', 'A'-'Z', 'a'-'z'
    function automatic logic kcd_is_alnum(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122);
    endfunction

endpackage

/* sv/keyboard_command_dispatcher.sv */
// Keyboard command dispatcher. A beat is taken in S_IDLE and evaluated in the next cycle, in
// S_EVAL, from the owner-table memory read; an error result is loaded into the output register
// from S_EVAL once that register is free. A return emits its N command bytes one per cycle from
// the command memory while the output is not stalled; a new beat is taken only in S_IDLE.
// Reset: owner entries read as empty via per-entry valid bits at once, no clearing pass;
// source id resets to 255, no command open.
`include "keyboard_command_dispatcher_assert.svh"

module keyboard_command_dispatcher
    import kcd_pkg::*;
#(
    parameter int MAX_COMMAND_BYTES = KCD_MAX_CMD_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_write,
    input  logic [7:0]           cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [7:0]           char_code,
    input  logic [7:0]           sender_id,
    // output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [7:0]           target_task,
    output logic [7:0]           data_byte,
    output logic [KCD_LEN_W-1:0] command_length,
    output logic                 last
);

    localparam int IDX_W = $clog2(MAX_COMMAND_BYTES);
    localparam int CNT_W = $clog2(MAX_COMMAND_BYTES + 1);
    localparam int OWN_W = $clog2(KCD_OWNER_DEPTH);

    // ---------------------------------------------------------------
    // Storage: owner table (128 x 8, valid bit per entry) and command
    // buffer (MAX_COMMAND_BYTES x 8, never cleared: only written
    // entries are ever read back).
    // ---------------------------------------------------------------
    logic [7:0]                 own_mem [KCD_OWNER_DEPTH];
    logic [KCD_OWNER_DEPTH-1:0] own_vld_reg;
    logic [7:0]                 own_rd_reg;
    logic                       own_vld_rd_reg;
    logic [7:0]                 cmd_mem [MAX_COMMAND_BYTES];
    logic [7:0]                 cmd_rd_reg;

    // control and item registers
    kcd_state_t        state_reg, state_next;
    logic [7:0]        src_reg;
    logic              in_cmd_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [7:0]        first_char_reg;
    logic [7:0]        task_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              mode_reg;
    logic [7:0]        char_reg;
    logic [7:0]        sender_reg;

    // output register
    logic                 out_valid_reg;
    logic [1:0]           kind_reg;
    logic [7:0]           target_reg;
    logic [7:0]           byte_reg;
    logic [KCD_LEN_W-1:0] len_reg;
    logic                 last_reg;

    // combinational
    kcd_act_t                 act;
    logic                     accept;
    logic                     out_free;
    logic                     out_load;
    logic [1:0]               load_kind;
    logic [7:0]               load_target;
    logic [7:0]               load_byte;
    logic [KCD_LEN_W-1:0]     load_len;
    logic                     load_last;
    logic                     is_err;
    logic                     last_byte;
    logic [7:0]               owner;
    logic                     alnum;
    logic [OWN_W-1:0]         own_raddr;
    logic                     own_we;
    logic                     cmd_we;
    logic [IDX_W-1:0]         cmd_raddr;
    logic [IDX_W-1:0]         idx_inc;
    logic [CNT_W-1:0]         cnt_m1;
    logic [CNT_W+KCD_LEN_W-1:0] cnt_ext;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign alnum    = kcd_is_alnum(char_reg);
    assign owner    = own_vld_rd_reg ? own_rd_reg : 8'd0;
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_ext  = (CNT_W + KCD_LEN_W)'(count_reg);
    assign idx_inc  = idx_reg + IDX_W'(1);
    assign last_byte = (idx_reg == cnt_m1[IDX_W-1:0]);

    // Once a command holds its identifier, the lookup is for the owner
    // of that identifier (checked again on return); otherwise for the key.
    assign own_raddr = (in_cmd_reg && count_reg != '0) ? first_char_reg[OWN_W-1:0]
                                                       : char_code[OWN_W-1:0];

    // ---------------------------------------------------------------
    // Item decode, valid in S_EVAL once the owner read has landed
    // ---------------------------------------------------------------
    always_comb
    begin
        act = ACT_NONE;
        if (!mode_reg) begin
            act = alnum ? ACT_REG : ACT_NONE;
        end else if (sender_reg != src_reg) begin
            act = ACT_NONE;
        end else if (!in_cmd_reg) begin
            act = (char_reg == KCD_CH_PERCENT) ? ACT_START : ACT_ERR_INV;
        end else if (count_reg == '0) begin
            act = (!alnum || owner == 8'd0) ? ACT_ERR_CANNOT : ACT_FIRST;
        end else if (char_reg == KCD_CH_CR) begin
            act = (owner == 8'd0) ? ACT_ERR_CANNOT : ACT_EMIT;
        end else if (count_reg >= CNT_W'(MAX_COMMAND_BYTES)) begin
            act = ACT_ERR_INV;
        end else if (!alnum) begin
            act = ACT_ERR_CANNOT;
        end else begin
            act = ACT_APPEND;
        end
    end

    assign is_err = (act == ACT_ERR_INV) || (act == ACT_ERR_CANNOT);

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (act == ACT_EMIT)
                    state_next = S_EMIT;
                else if (!is_err || out_free)
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free && last_byte)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs of the state machine
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready    = 1'b0;
        out_load    = 1'b0;
        load_kind   = KCD_KIND_BYTE;
        load_target = 8'd0;
        load_byte   = 8'd0;
        load_len    = '0;
        load_last   = 1'b1;
        own_we      = 1'b0;
        cmd_we      = 1'b0;
        cmd_raddr   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_EVAL:
            begin
                own_we = (act == ACT_REG);
                cmd_we = (act == ACT_FIRST) || (act == ACT_APPEND);
                if (is_err && out_free) begin
                    out_load  = 1'b1;
                    load_kind = (act == ACT_ERR_INV) ? KCD_KIND_INVALID : KCD_KIND_CANNOT;
                end
            end
            S_EMIT:
            begin
                // prefetch the next byte when this one goes out
                cmd_raddr   = out_free ? idx_inc : idx_reg;
                out_load    = out_free;
                load_kind   = KCD_KIND_BYTE;
                load_target = task_reg;
                load_byte   = cmd_rd_reg;
                load_len    = cnt_ext[KCD_LEN_W-1:0];
                load_last   = last_byte;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept) begin
            own_rd_reg     <= own_mem[own_raddr];
            own_vld_rd_reg <= own_vld_reg[own_raddr];
        end
        if (own_we)
            own_mem[char_reg[OWN_W-1:0]] <= sender_reg;
    end

    always_ff @(posedge clk)
    begin
        cmd_rd_reg <= cmd_mem[cmd_raddr];
        if (cmd_we)
            cmd_mem[count_reg[IDX_W-1:0]] <= char_reg;
    end

    // item and payload registers
    always_ff @(posedge clk)
    begin
        if (accept) begin
            mode_reg   <= mode;
            char_reg   <= char_code;
            sender_reg <= sender_id;
        end
        if (state_reg == S_EVAL && act == ACT_EMIT)
            task_reg <= owner;
        if (state_reg == S_EVAL && act == ACT_FIRST)
            first_char_reg <= char_reg;
        if (out_load) begin
            kind_reg   <= load_kind;
            target_reg <= load_target;
            byte_reg   <= load_byte;
            len_reg    <= load_len;
            last_reg   <= load_last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            src_reg       <= KCD_SOURCE_RESET;
            in_cmd_reg    <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            own_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_write)
                src_reg <= cfg_data;
            if (own_we)
                own_vld_reg[char_reg[OWN_W-1:0]] <= 1'b1;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (state_reg == S_EVAL) begin
                case (act)
                    ACT_START:
                    begin
                        in_cmd_reg <= 1'b1;
                        count_reg  <= '0;
                    end
                    ACT_FIRST, ACT_APPEND:
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    ACT_EMIT:
                    begin
                        idx_reg <= '0;
                    end
                    ACT_ERR_INV, ACT_ERR_CANNOT:
                    begin
                        if (out_free) begin
                            in_cmd_reg <= 1'b0;
                            count_reg  <= '0;
                        end
                    end
                    default: ;
                endcase
            end else if (state_reg == S_EMIT && out_free) begin
                idx_reg <= idx_inc;
                if (last_byte) begin
                    in_cmd_reg <= 1'b0;
                    count_reg  <= '0;
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign target_task    = target_reg;
    assign data_byte      = byte_reg;
    assign command_length = len_reg;
    assign last           = last_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `KCD_ASSERT_NEXT(a_accept_eval, accept, state_reg == S_EVAL, "beat not evaluated")
    `KCD_ASSERT_NOW(a_emit_bounds, state_reg == S_EMIT,
        count_reg != '0 && in_cmd_reg, "emit without buffered command")
    `KCD_ASSERT_NOW(a_err_shape, out_valid_reg && kind_reg != KCD_KIND_BYTE,
        target_reg == 8'd0 && len_reg == '0 && last_reg, "malformed error result")
    `KCD_ASSERT_NEXT(a_emit_close, state_reg == S_EMIT && out_free && last_byte,
        state_reg == S_IDLE && !in_cmd_reg && count_reg == '0, "command not closed")

endmodule
